// ===== hdl/ltpsm_pkg.sv =====
// Package for the LED tile pixel scan mapper: register map, field widths, defaults.
package ltpsm_pkg;

   // default values of the top-level parameters
   localparam int HEADER_BYTES_DEFAULT = 24;
   localparam int DATA_BYTES_DEFAULT   = 512;
   localparam int ADDR_BITS_DEFAULT    = 24;
   localparam int MAX_TILE_DIM_DEFAULT = 32;

   // fixed field widths
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int MODE_W     = 1;
   localparam int DIM_REG_W  = 6;
   localparam int ADR_W      = 24;
   localparam int CHAN_W     = 4;
   localparam int OFFSET_W   = 10;
   localparam int PIXEL_BYTES = 3;

   // register index, byte address = 4 * index
   typedef enum logic [2:0] {
      REG_LAYOUT_MODE   = 3'd0,
      REG_TILE_WIDTH    = 3'd1,
      REG_TILE_HEIGHT   = 3'd2,
      REG_BASE_OFFSET   = 3'd3,
      REG_COLUMN_STRIDE = 3'd4,
      REG_ROW_STRIDE    = 3'd5,
      REG_START_CHANNEL = 3'd6
   } reg_index_type;

   // register reset values
   localparam logic [MODE_W-1:0]    LAYOUT_MODE_RESET   = 1'b0;
   localparam logic [DIM_REG_W-1:0] TILE_WIDTH_RESET    = 6'd12;
   localparam logic [DIM_REG_W-1:0] TILE_HEIGHT_RESET   = 6'd12;
   localparam logic [ADR_W-1:0]     BASE_OFFSET_RESET   = 24'd0;
   localparam logic [ADR_W-1:0]     COLUMN_STRIDE_RESET = 24'd3;
   localparam logic [ADR_W-1:0]     ROW_STRIDE_RESET    = 24'd0;
   localparam logic [CHAN_W-1:0]    START_CHANNEL_RESET = 4'd1;

endpackage

// ===== hdl/led_tile_pixel_scan_mapper.sv =====
// LED tile pixel scan mapper: scan counter, address/offset pipeline and register file.

// Each accepted request item yields one response item describing the next pixel of the
// tile scan (source byte address, packet, byte offset in the packet, end-of-frame flag);
// a set restart bit jumps to the first pixel of the frame before that pixel is produced,
// and any write to a mapped register also restarts the scan. One item is accepted per clock
// while req_stall is low; the first stage steps the scan position and registers the two
// stride products, the response register adds them onto the base address. Throughput is
// limited only by the response side; req_stall is raised when both stages hold items and
// the response register is stalled. Registers sit at byte address 4*index on the APB
// port, which never inserts wait states; write them only while no item is in flight.
module led_tile_pixel_scan_mapper
   import ltpsm_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT,
   parameter int DATA_BYTES   = DATA_BYTES_DEFAULT,
   parameter int ADDR_BITS    = ADDR_BITS_DEFAULT,
   parameter int MAX_TILE_DIM = MAX_TILE_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_restart,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADR_W-1:0]      rsp_source_address,
   output logic [CHAN_W-1:0]     rsp_dest_packet,
   output logic [OFFSET_W-1:0]   rsp_dest_offset,
   output logic                  rsp_offset_overflow,
   output logic                  rsp_last_of_frame,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int POS_W = (MAX_TILE_DIM > 2) ? $clog2(MAX_TILE_DIM) : 1;
   localparam int DIM_W = $clog2(MAX_TILE_DIM + 1);
   localparam int PIH_W = $clog2(MAX_TILE_DIM * ((MAX_TILE_DIM + 1) / 2));
   localparam int PIX_LIMIT = DATA_BYTES / PIXEL_BYTES;
   localparam logic [63:0] ADDR_MASK_FULL = (64'd1 << ADDR_BITS) - 64'd1;
   localparam logic [ADR_W-1:0] ADDR_MASK = ADDR_MASK_FULL[ADR_W-1:0];

   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             second_half;
      logic [PIH_W-1:0] pixel_in_half;
   } scan_pos_type;

   // ---------------- registers ----------------
   logic [MODE_W-1:0]    layout_mode_ff;
   logic [DIM_REG_W-1:0] tile_width_ff;
   logic [DIM_REG_W-1:0] tile_height_ff;
   logic [ADR_W-1:0]     base_offset_ff;
   logic [ADR_W-1:0]     column_stride_ff;
   logic [ADR_W-1:0]     row_stride_ff;
   logic [CHAN_W-1:0]    start_channel_ff;

   logic          csr_write;
   reg_index_type csr_index;
   logic          csr_known;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      csr_known = 1'b1;
      prdata    = '0;
      unique case (csr_index)
         REG_LAYOUT_MODE:   prdata = CSR_DATA_W'(layout_mode_ff);
         REG_TILE_WIDTH:    prdata = CSR_DATA_W'(tile_width_ff);
         REG_TILE_HEIGHT:   prdata = CSR_DATA_W'(tile_height_ff);
         REG_BASE_OFFSET:   prdata = CSR_DATA_W'(base_offset_ff);
         REG_COLUMN_STRIDE: prdata = CSR_DATA_W'(column_stride_ff);
         REG_ROW_STRIDE:    prdata = CSR_DATA_W'(row_stride_ff);
         REG_START_CHANNEL: prdata = CSR_DATA_W'(start_channel_ff);
         default:           csr_known = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_mode_ff   <= LAYOUT_MODE_RESET;
         tile_width_ff    <= TILE_WIDTH_RESET;
         tile_height_ff   <= TILE_HEIGHT_RESET;
         base_offset_ff   <= BASE_OFFSET_RESET;
         column_stride_ff <= COLUMN_STRIDE_RESET;
         row_stride_ff    <= ROW_STRIDE_RESET;
         start_channel_ff <= START_CHANNEL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_LAYOUT_MODE:   layout_mode_ff   <= pwdata[MODE_W-1:0];
            REG_TILE_WIDTH:    tile_width_ff    <= pwdata[DIM_REG_W-1:0];
            REG_TILE_HEIGHT:   tile_height_ff   <= pwdata[DIM_REG_W-1:0];
            REG_BASE_OFFSET:   base_offset_ff   <= pwdata[ADR_W-1:0];
            REG_COLUMN_STRIDE: column_stride_ff <= pwdata[ADR_W-1:0];
            REG_ROW_STRIDE:    row_stride_ff    <= pwdata[ADR_W-1:0];
            REG_START_CHANNEL: start_channel_ff <= pwdata[CHAN_W-1:0];
            default:           ;
         endcase
      end
   end

   // ---------------- clamped dimensions ----------------
   logic [DIM_W-1:0] width;
   logic [DIM_W-1:0] height;

   always_comb begin
      if (tile_width_ff < DIM_REG_W'(2))
         width = DIM_W'(2);
      else if (32'(tile_width_ff) > 32'(MAX_TILE_DIM))
         width = DIM_W'(MAX_TILE_DIM);
      else
         width = DIM_W'(tile_width_ff);
      if (tile_height_ff < DIM_REG_W'(2))
         height = DIM_W'(2);
      else if (32'(tile_height_ff) > 32'(MAX_TILE_DIM))
         height = DIM_W'(MAX_TILE_DIM);
      else
         height = DIM_W'(tile_height_ff);
   end

   logic [POS_W-1:0] last_col;
   logic [POS_W-1:0] last_row;
   logic [POS_W-1:0] half_col;
   logic [POS_W-1:0] half_row;

   assign last_col = POS_W'(width - DIM_W'(1));
   assign last_row = POS_W'(height - DIM_W'(1));
   assign half_col = POS_W'(width >> 1);
   assign half_row = POS_W'(height >> 1);

   // ---------------- scan state ----------------
   scan_pos_type pos_ff;
   logic         restart_pending_ff;   // a register write forces the first pixel
   scan_pos_type first_pos;
   scan_pos_type cur_pos;
   scan_pos_type next_pos;
   logic         cur_last;
   logic         req_take;
   logic         s1_load_ok;

   always_comb begin
      first_pos = '0;
      if (layout_mode_ff == 1'b0) begin
         first_pos.col = last_col;
         first_pos.row = half_row - POS_W'(1);
      end else begin
         first_pos.col = '0;
         first_pos.row = last_row;
      end
   end

   assign cur_pos = (req_restart || restart_pending_ff) ? first_pos : pos_ff;

   always_comb begin
      if (!cur_pos.second_half)
         cur_last = 1'b0;
      else if (layout_mode_ff == 1'b0)
         cur_last = (cur_pos.col == '0) && (cur_pos.row == last_row);
      else
         cur_last = (cur_pos.col == last_col) && (cur_pos.row == '0);
   end

   always_comb begin
      next_pos = cur_pos;
      next_pos.pixel_in_half = cur_pos.pixel_in_half + PIH_W'(1);
      if (cur_last) begin
         next_pos = first_pos;
      end else if (layout_mode_ff == 1'b0) begin
         if (cur_pos.col != '0) begin
            next_pos.col = cur_pos.col - POS_W'(1);
         end else begin
            next_pos.col = last_col;
            if (cur_pos.second_half) begin
               next_pos.row = cur_pos.row + POS_W'(1);
            end else if (cur_pos.row == '0) begin
               // top half done, switch to the bottom half
               next_pos.row           = half_row;
               next_pos.second_half   = 1'b1;
               next_pos.pixel_in_half = '0;
            end else begin
               next_pos.row = cur_pos.row - POS_W'(1);
            end
         end
      end else begin
         if (cur_pos.col < (cur_pos.second_half ? last_col : half_col - POS_W'(1))) begin
            next_pos.col = cur_pos.col + POS_W'(1);
         end else if (cur_pos.row != '0) begin
            next_pos.col = cur_pos.second_half ? half_col : '0;
            next_pos.row = cur_pos.row - POS_W'(1);
         end else begin
            // left half done, switch to the right half
            next_pos.col           = half_col;
            next_pos.row           = last_row;
            next_pos.second_half   = 1'b1;
            next_pos.pixel_in_half = '0;
         end
      end
   end

   assign req_take  = req_valid && !req_stall;
   assign req_stall = !s1_load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff             <= '0;
         restart_pending_ff <= 1'b1;
      end else if (csr_write && csr_known) begin
         restart_pending_ff <= 1'b1;
      end else if (req_take) begin
         pos_ff             <= next_pos;
         restart_pending_ff <= 1'b0;
      end
   end

   // ---------------- stage 1: products and packet fields ----------------
   logic [PIH_W+1:0]    pix_bytes;
   logic                over_in;
   logic [ADR_W-1:0]    col_prod_in;
   logic [ADR_W-1:0]    row_prod_in;

   logic                s1_valid_ff;
   logic [ADR_W-1:0]    s1_col_prod_ff;
   logic [ADR_W-1:0]    s1_row_prod_ff;
   logic [CHAN_W-1:0]   s1_packet_ff;
   logic [OFFSET_W-1:0] s1_offset_ff;
   logic                s1_over_ff;
   logic                s1_last_ff;
   logic                out_load;

   assign pix_bytes   = (PIH_W+2)'({cur_pos.pixel_in_half, 1'b0})
                      + (PIH_W+2)'(cur_pos.pixel_in_half);
   assign over_in     = 32'(cur_pos.pixel_in_half) >= 32'(PIX_LIMIT);
   assign col_prod_in = ADR_W'(ADR_W'(cur_pos.col) * column_stride_ff);
   assign row_prod_in = ADR_W'(ADR_W'(cur_pos.row) * row_stride_ff);

   assign out_load   = s1_valid_ff && (!rsp_valid || !rsp_stall);
   assign s1_load_ok = !s1_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load_ok) begin
         s1_valid_ff <= req_valid;
      end
      if (req_take) begin
         s1_col_prod_ff <= col_prod_in;
         s1_row_prod_ff <= row_prod_in;
         s1_packet_ff   <= start_channel_ff - CHAN_W'(1)
                         + CHAN_W'(cur_pos.second_half);
         s1_offset_ff   <= over_in ? '0
                         : OFFSET_W'(32'(HEADER_BYTES) + 32'(pix_bytes));
         s1_over_ff     <= over_in;
         s1_last_ff     <= cur_last;
      end
   end

   // ---------------- stage 2: address sum, response register ----------------
   logic rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (out_load) begin
         rsp_source_address  <= (base_offset_ff + s1_col_prod_ff + s1_row_prod_ff)
                              & ADDR_MASK;
         rsp_dest_packet     <= s1_packet_ff;
         rsp_dest_offset     <= s1_offset_ff;
         rsp_offset_overflow <= s1_over_ff;
         rsp_last_of_frame   <= s1_last_ff;
      end
   end

endmodule

// ===== hdl/ltpsm_checker.sv =====
// Port-level checks for the LED tile pixel scan mapper, bound to the top level.
module ltpsm_checker
   import ltpsm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [ADR_W-1:0]    rsp_source_address,
   input logic [OFFSET_W-1:0] rsp_dest_offset,
   input logic                rsp_offset_overflow,
   input logic                rsp_last_of_frame
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the request side is held back only by a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without response backpressure");

   // an overflowing pixel carries no offset
   a_overflow_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_offset_overflow) |-> (rsp_dest_offset == '0))
      else $error("offset not cleared on overflow");

   // a stalled response holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_source_address)
                                    && $stable(rsp_dest_offset)
                                    && $stable(rsp_last_of_frame)))
      else $error("stalled response changed");

endmodule

bind led_tile_pixel_scan_mapper ltpsm_checker u_ltpsm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_source_address  (rsp_source_address),
   .rsp_dest_offset     (rsp_dest_offset),
   .rsp_offset_overflow (rsp_offset_overflow),
   .rsp_last_of_frame   (rsp_last_of_frame)
);

// ===== tb/led_tile_pixel_scan_mapper_tb.sv =====
// Self-checking bench for the LED tile pixel scan mapper: directed table, then random phases.
module led_tile_pixel_scan_mapper_tb;
   import ltpsm_pkg::*;

   localparam int RESET_CYCLES   = 11;
   localparam int TIMEOUT_CYCLES = 500000;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_PRINTS     = 40;
   localparam int NUM_REGS       = 7;
   localparam int DIR_ROWS       = 36;
   localparam logic [2:0] UNUSED_REG = 3'd7;

   typedef struct packed {
      logic [ADR_W-1:0]    addr;
      logic [CHAN_W-1:0]   pkt;
      logic [OFFSET_W-1:0] off;
      logic                ovf;
      logic                last;
   } pixel_type;

   typedef enum {ROW_WRITE, ROW_PIXEL} dir_kind_type;

   typedef struct {
      dir_kind_type kind;
      logic [2:0]   reg_idx;
      logic [31:0]  value;
      bit           restart;
      int           count;
      bit           typed;
      pixel_type    want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_restart = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ADR_W-1:0]    rsp_source_address;
   logic [CHAN_W-1:0]   rsp_dest_packet;
   logic [OFFSET_W-1:0] rsp_dest_offset;
   logic rsp_offset_overflow;
   logic rsp_last_of_frame;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   led_tile_pixel_scan_mapper DUT (.*);

   // scan model state and register copy
   logic [31:0] reg_file [NUM_REGS];
   int scan_col, scan_row, scan_pix;
   bit scan_second;
   pixel_type pending_pixels [$];

   int n_items, n_results, n_writes, n_errors, n_overflow, n_frames, n_phases;
   int cycle_count;
   int stall_kind, stall_left, stall_tick;
   pixel_type got_pixel, want_pixel;
   int dim_corners [7] = '{0, 1, 2, 31, 32, 33, 63};

   dir_row_type dir_table [DIR_ROWS] = '{
      // reset layout 12x12, row halves
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b1, '{24'd33, 4'd0, 10'd24, 1'b0, 1'b0}},
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b1, '{24'd30, 4'd0, 10'd27, 1'b0, 1'b0}},
      // unmapped index must not disturb the scan
      '{ROW_WRITE, UNUSED_REG, 32'hFFFF_FFFF, 1'b0, 0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b1, '{24'd27, 4'd0, 10'd30, 1'b0, 1'b0}},
      '{ROW_PIXEL, '0, '0, 1'b1, 1, 1'b1, '{24'd33, 4'd0, 10'd24, 1'b0, 1'b0}},
      // smallest tile, all-ones address terms, packet wrap from channel 0
      '{ROW_WRITE, REG_START_CHANNEL, 32'd0, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_TILE_WIDTH, 32'd2, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_TILE_HEIGHT, 32'd2, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_BASE_OFFSET, 32'hFF_FFFF, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_COLUMN_STRIDE, 32'hFF_FFFF, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_ROW_STRIDE, 32'hFF_FFFF, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_LAYOUT_MODE, 32'd0, 1'b0, 0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b1, '{24'hFFFFFE, 4'd15, 10'd24, 1'b0, 1'b0}},
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b1, '{24'hFFFFFF, 4'd15, 10'd27, 1'b0, 1'b0}},
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b1, '{24'hFFFFFD, 4'd0, 10'd24, 1'b0, 1'b0}},
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b1, '{24'hFFFFFE, 4'd0, 10'd27, 1'b0, 1'b1}},
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b1, '{24'hFFFFFE, 4'd15, 10'd24, 1'b0, 1'b0}},
      // column halves, dimensions below range
      '{ROW_WRITE, REG_LAYOUT_MODE, 32'd1, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_TILE_WIDTH, 32'd1, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_TILE_HEIGHT, 32'd0, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_BASE_OFFSET, 32'd0, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_COLUMN_STRIDE, 32'd1, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_ROW_STRIDE, 32'd16, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_START_CHANNEL, 32'd15, 1'b0, 0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 1'b0, 4, 1'b0, '0},
      // odd width splits 1 + 2 columns
      '{ROW_WRITE, REG_TILE_WIDTH, 32'd3, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_TILE_HEIGHT, 32'd2, 1'b0, 0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 1'b0, 7, 1'b0, '0},
      // odd height splits 1 + 2 rows
      '{ROW_WRITE, REG_LAYOUT_MODE, 32'd0, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_TILE_HEIGHT, 32'd3, 1'b0, 0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 1'b0, 3, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 1'b1, 1, 1'b0, '0},
      // dimensions above range saturate
      '{ROW_WRITE, REG_TILE_WIDTH, 32'd33, 1'b0, 0, 1'b0, '0},
      '{ROW_WRITE, REG_TILE_HEIGHT, 32'd63, 1'b0, 0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 1'b0, 1, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 1'b1, 1, 1'b0, '0}
   };

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] field_mask(input logic [2:0] idx);
      case (idx)
         REG_LAYOUT_MODE:   return 32'h1;
         REG_TILE_WIDTH,
         REG_TILE_HEIGHT:   return 32'h3F;
         REG_BASE_OFFSET,
         REG_COLUMN_STRIDE,
         REG_ROW_STRIDE:    return 32'hFF_FFFF;
         REG_START_CHANNEL: return 32'hF;
         default:           return 32'h0;
      endcase
   endfunction

   function automatic int eff_dim(input logic [31:0] v);
      if (v < 2) return 2;
      if (v > MAX_TILE_DIM_DEFAULT) return MAX_TILE_DIM_DEFAULT;
      return int'(v);
   endfunction

   function automatic void scan_home();
      int w, h;
      w = eff_dim(reg_file[REG_TILE_WIDTH]);
      h = eff_dim(reg_file[REG_TILE_HEIGHT]);
      if (reg_file[REG_LAYOUT_MODE][0] == 1'b0) begin
         scan_col = w - 1;
         scan_row = h / 2 - 1;
      end else begin
         scan_col = 0;
         scan_row = h - 1;
      end
      scan_second = 1'b0;
      scan_pix = 0;
   endfunction

   function automatic bit scan_at_end();
      int w, h;
      w = eff_dim(reg_file[REG_TILE_WIDTH]);
      h = eff_dim(reg_file[REG_TILE_HEIGHT]);
      if (!scan_second) return 1'b0;
      if (reg_file[REG_LAYOUT_MODE][0] == 1'b0) return scan_col == 0 && scan_row == h - 1;
      return scan_col == w - 1 && scan_row == 0;
   endfunction

   function automatic void scan_step();
      int w, h, half, first_col, last_col;
      w = eff_dim(reg_file[REG_TILE_WIDTH]);
      h = eff_dim(reg_file[REG_TILE_HEIGHT]);
      half = w / 2;
      if (scan_at_end()) begin
         scan_home();
         return;
      end
      scan_pix++;
      if (reg_file[REG_LAYOUT_MODE][0] == 1'b0) begin
         if (scan_col > 0) begin
            scan_col--;
            return;
         end
         scan_col = w - 1;
         if (!scan_second) begin
            if (scan_row == 0) begin
               scan_row = h / 2;
               scan_second = 1'b1;
               scan_pix = 0;
            end else begin
               scan_row--;
            end
         end else begin
            scan_row++;
         end
      end else begin
         first_col = scan_second ? half : 0;
         last_col = scan_second ? w - 1 : half - 1;
         if (scan_col < last_col) begin
            scan_col++;
            return;
         end
         scan_col = first_col;
         if (scan_row > 0) begin
            scan_row--;
         end else begin
            // first half done: jump to the bottom row of the right half
            scan_second = 1'b1;
            scan_row = h - 1;
            scan_col = half;
            scan_pix = 0;
         end
      end
   endfunction

   function automatic pixel_type next_pixel(input bit restart);
      pixel_type px;
      logic [63:0] sum;
      int data_pos;
      if (restart) scan_home();
      sum = 64'(reg_file[REG_BASE_OFFSET])
          + 64'(scan_col) * 64'(reg_file[REG_COLUMN_STRIDE])
          + 64'(scan_row) * 64'(reg_file[REG_ROW_STRIDE]);
      px.addr = sum[ADR_W-1:0];
      px.pkt = CHAN_W'(reg_file[REG_START_CHANNEL] + 15 + scan_second);
      data_pos = PIXEL_BYTES * scan_pix;
      px.ovf = (data_pos + PIXEL_BYTES) > DATA_BYTES_DEFAULT;
      px.off = px.ovf ? '0 : OFFSET_W'(HEADER_BYTES_DEFAULT + data_pos);
      px.last = scan_at_end();
      scan_step();
      return px;
   endfunction

   function automatic logic [31:0] pick_dim();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(2, 6);
         4, 5, 6:    return $urandom_range(2, 32);
         default:    return dim_corners[$urandom_range(0, 6)];
      endcase
   endfunction

   function automatic logic [31:0] pick_word24();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFF_FFFF;
         2, 3:    return $urandom_range(0, 255);
         default: return $urandom & 32'hFF_FFFF;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      n_errors++;
      if (n_errors <= MAX_PRINTS)
         $display("%0t: %s: got 0x%0h, expected 0x%0h (result %0d)",
                  $time, what, got, want, n_results);
   endtask

   // drop valid and wait until every pixel in flight has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_readback(input logic [2:0] idx);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== reg_file[idx]) report_mismatch("register readback", prdata, reg_file[idx]);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      settle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx < NUM_REGS) begin
         reg_file[idx] = value & field_mask(idx);
         scan_home();
      end
      n_writes++;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      if (idx < NUM_REGS) csr_readback(idx);
   endtask

   task automatic push_item(input bit restart, input bit typed, input pixel_type typed_want);
      pixel_type px;
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      px = next_pixel(restart);
      pending_pixels.insert(pending_pixels.size(), typed ? typed_want : px);
      n_items++;
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      req_restart <= $urandom_range(0, 1);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_stream(input int count, input int restart_odds);
      int left, burst, gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left) burst = left;
         repeat (burst)
            push_item(restart_odds != 0 && $urandom_range(0, restart_odds - 1) == 0,
                      1'b0, '0);
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0 && left > 0) idle_gap(gap);
      end
   endtask

   // phases 0 and 1 pin a long narrow tile so each half runs past the packet end
   task automatic config_phase(input int phase);
      logic [31:0] v;
      bit any, skip;
      int idx;
      any = 1'b0;
      for (idx = 0; idx < NUM_REGS; idx++) begin
         skip = (phase >= 2) && ($urandom_range(0, 1) == 0);
         if (idx == NUM_REGS - 1 && !any) skip = 1'b0;
         if (!skip) begin
            case (idx)
               REG_LAYOUT_MODE:   v = (phase < 2) ? phase : $urandom_range(0, 1);
               REG_TILE_WIDTH:    v = (phase == 0) ? 32 : (phase == 1) ? 12 : pick_dim();
               REG_TILE_HEIGHT:   v = (phase == 0) ? 12 : (phase == 1) ? 32 : pick_dim();
               REG_START_CHANNEL: v = $urandom_range(0, 15);
               default:           v = pick_word24();
            endcase
            if ($urandom_range(0, 7) == 0) v |= $urandom & ~field_mask(3'(idx));
            csr_write(3'(idx), v);
            any = 1'b1;
         end
      end
   endtask

   // result side: stall pattern and checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
         end else begin
            stall_left--;
         end
         stall_tick++;
         case (stall_kind)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 2) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_tick % 7) < 3;
         endcase
         if (rsp_valid && !rsp_stall) begin
            got_pixel = {rsp_source_address, rsp_dest_packet, rsp_dest_offset,
                         rsp_offset_overflow, rsp_last_of_frame};
            n_results++;
            if (got_pixel.ovf === 1'b1) n_overflow++;
            if (got_pixel.last === 1'b1) n_frames++;
            if (pending_pixels.size() == 0) begin
               report_mismatch("transfer with nothing pending", 32'(got_pixel.addr), 32'd0);
            end else begin
               want_pixel = pending_pixels.pop_front();
               if (got_pixel.addr !== want_pixel.addr)
                  report_mismatch("source_address", 32'(got_pixel.addr),
                                  32'(want_pixel.addr));
               if (got_pixel.pkt !== want_pixel.pkt)
                  report_mismatch("dest_packet", 32'(got_pixel.pkt), 32'(want_pixel.pkt));
               if (got_pixel.off !== want_pixel.off)
                  report_mismatch("dest_offset", 32'(got_pixel.off), 32'(want_pixel.off));
               if (got_pixel.ovf !== want_pixel.ovf)
                  report_mismatch("offset_overflow", 32'(got_pixel.ovf), 32'(want_pixel.ovf));
               if (got_pixel.last !== want_pixel.last)
                  report_mismatch("last_of_frame", 32'(got_pixel.last),
                                  32'(want_pixel.last));
            end
         end
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < TIMEOUT_CYCLES; cycle_count++) @(posedge clock);
      $display("run stopped after %0d cycles with %0d pixels outstanding",
               cycle_count, pending_pixels.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int row, gap, sent, odds, len;
      reg_file[REG_LAYOUT_MODE]   = 32'(LAYOUT_MODE_RESET);
      reg_file[REG_TILE_WIDTH]    = 32'(TILE_WIDTH_RESET);
      reg_file[REG_TILE_HEIGHT]   = 32'(TILE_HEIGHT_RESET);
      reg_file[REG_BASE_OFFSET]   = 32'(BASE_OFFSET_RESET);
      reg_file[REG_COLUMN_STRIDE] = 32'(COLUMN_STRIDE_RESET);
      reg_file[REG_ROW_STRIDE]    = 32'(ROW_STRIDE_RESET);
      reg_file[REG_START_CHANNEL] = 32'(START_CHANNEL_RESET);
      scan_home();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset values of every register
      for (row = 0; row < NUM_REGS; row++) csr_readback(3'(row));

      for (row = 0; row < DIR_ROWS; row++) begin
         if (dir_table[row].kind == ROW_WRITE) begin
            csr_write(dir_table[row].reg_idx, dir_table[row].value);
         end else begin
            repeat (dir_table[row].count) begin
               push_item(dir_table[row].restart, dir_table[row].typed, dir_table[row].want);
               gap = $urandom_range(0, 2);
               if (gap > 0) idle_gap(gap);
            end
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         config_phase(n_phases);
         case ($urandom_range(0, 2))
            0:       odds = 0;
            1:       odds = 64;
            default: odds = 4;
         endcase
         if (n_phases < 2) odds = 0;
         len = (n_phases < 2) ? 400 : $urandom_range(20, 300);
         send_stream(len, odds);
         sent += len;
         n_phases++;
      end

      settle();
      $display("%0d pixel requests over %0d directed rows and %0d random phases, %0d CSR writes",
               n_items, DIR_ROWS, n_phases, n_writes);
      $display("%0d pixels checked: %0d past the packet end, %0d frame ends, %0d mismatches",
               n_results, n_overflow, n_frames, n_errors);
      if (n_errors == 0 && pending_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
